// File: rtl/sssa_pkg.sv
package sssa_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SPLAT = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [1:0] REG_DENSITY    = 2'd0;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd2;

  localparam logic [7:0] DENSITY_RESET = 8'd1;
  localparam logic [8:0] SIDE_RESET    = 9'd256;

  typedef struct packed {
    logic capture;
    logic scale;
    logic div_start;
    logic div_y;
    logic walk_init;
    logic clear_step;
    logic splat_step;
    logic load_write;
    logic read_issue;
    logic resp_load;
    logic resp_err;
    logic resp_read;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic dims_ok;
    logic load_ok;
    logic read_ok;
    logic div_busy;
    logic texel_last;
    logic clear_last;
  } stat_t;

endpackage

// File: rtl/sssa_datapath.sv
module sssa_datapath #(
  parameter int STAMP_SIDE    = 16,
  parameter int MAP_SIDE_MAX  = 256,
  parameter int POS_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic [1:0]          s_tuser,
  input  logic [55:0]         s_tdata,
  input  sssa_pkg::cmd_t      cmd,
  output sssa_pkg::stat_t     stat,
  output logic [7:0]          m_tdata,
  output logic                m_tuser
);

  localparam int STAMP_CELLS = STAMP_SIDE * STAMP_SIDE;
  localparam int TW          = $clog2(STAMP_CELLS);
  localparam int SXW         = $clog2(STAMP_SIDE);
  localparam int HALF        = STAMP_SIDE / 2;
  localparam int MAP_CELLS   = MAP_SIDE_MAX * MAP_SIDE_MAX;
  localparam int MAW         = $clog2(MAP_CELLS);
  localparam int PRW         = 24;
  localparam int RW          = PRW + 2;
  localparam int DW          = RW - 1;
  localparam int CW          = $clog2(DW + 1);
  localparam int AW          = 18;

  logic [7:0]  density;
  logic [8:0]  map_width;
  logic [8:0]  map_height;

  sssa_pkg::op_t      op_q;
  logic [15:0]        idx_q;
  logic [7:0]         val_q;
  logic signed [15:0] posx_q;
  logic signed [15:0] posy_q;
  logic [AW-1:0]      area;

  logic signed [RW-1:0] raw_x;
  logic signed [RW-1:0] raw_y;

  logic [DW-1:0] dvd;
  logic [8:0]    rem;
  logic [8:0]    modulus;
  logic          div_neg;
  logic          div_y;
  logic          div_busy;
  logic [CW-1:0] div_cnt;
  logic [8:0]    x0;
  logic [8:0]    y0;

  logic [AW-1:0] base;
  logic [8:0]    wx;
  logic [8:0]    wy;
  logic [SXW-1:0] sx;
  logic [TW-1:0] tcnt;
  logic [AW-1:0] clr_cnt;

  logic [MAW-1:0] p1_addr;
  logic           p1_valid;
  logic [MAW-1:0] p2_addr;
  logic           p2_valid;
  logic [7:0]     p2_sum;

  logic [7:0] map_mem [MAP_CELLS];
  logic [7:0] stamp_mem [STAMP_CELLS];
  logic [7:0] map_q;
  logic [7:0] stamp_q;

  logic [15:0]          mag_x;
  logic [15:0]          mag_y;
  logic [PRW-1:0]       sc_x;
  logic [PRW-1:0]       sc_y;
  logic signed [RW-1:0] rx_c;
  logic signed [RW-1:0] ry_c;
  logic signed [RW-1:0] raw_sel;
  logic [RW-1:0]        raw_abs;
  logic [9:0]           trial;
  logic [8:0]           rem_next;
  logic [8:0]           wrapped;
  logic [MAW-1:0]       walk_addr;
  logic [7:0]           sum;
  logic                 dims_ok;

  assign dims_ok = (map_width != 9'd0) && (32'(map_width) <= MAP_SIDE_MAX) &&
                   (map_height != 9'd0) && (32'(map_height) <= MAP_SIDE_MAX);

  always_comb begin
    stat.op         = op_q;
    stat.dims_ok    = dims_ok;
    stat.load_ok    = 32'(idx_q) < STAMP_CELLS;
    stat.read_ok    = dims_ok && (AW'(idx_q) < area);
    stat.div_busy   = div_busy;
    stat.texel_last = (32'(tcnt) == STAMP_CELLS - 1);
    stat.clear_last = (clr_cnt == area - AW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      density    <= sssa_pkg::DENSITY_RESET;
      map_width  <= sssa_pkg::SIDE_RESET;
      map_height <= sssa_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sssa_pkg::REG_DENSITY:    density    <= cfg_data[7:0];
        sssa_pkg::REG_MAP_WIDTH:  map_width  <= cfg_data;
        sssa_pkg::REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= sssa_pkg::op_t'(s_tuser);
      idx_q  <= s_tdata[15:0];
      val_q  <= s_tdata[23:16];
      posx_q <= s_tdata[39:24];
      posy_q <= s_tdata[55:40];
      area   <= AW'(map_width) * AW'(map_height);
    end
  end

  // scale by density, truncate the magnitude, then step back to the stamp corner
  always_comb begin
    mag_x = posx_q[15] ? 16'(-posx_q) : posx_q;
    mag_y = posy_q[15] ? 16'(-posy_q) : posy_q;
    sc_x  = PRW'((PRW'(mag_x) * PRW'(density)) >> POS_FRAC_BITS);
    sc_y  = PRW'((PRW'(mag_y) * PRW'(density)) >> POS_FRAC_BITS);
    rx_c  = (posx_q[15] ? -$signed({2'b00, sc_x}) : $signed({2'b00, sc_x})) - RW'(HALF);
    ry_c  = (posy_q[15] ? -$signed({2'b00, sc_y}) : $signed({2'b00, sc_y})) - RW'(HALF);
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      raw_x <= rx_c;
      raw_y <= ry_c;
    end
  end

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    raw_sel  = cmd.div_y ? raw_y : raw_x;
    raw_abs  = raw_sel[RW-1] ? RW'(-raw_sel) : RW'(raw_sel);
    trial    = {rem, dvd[DW-1]};
    rem_next = (trial >= {1'b0, modulus}) ? 9'(trial - {1'b0, modulus}) : trial[8:0];
    wrapped  = (div_neg && rem_next != 9'd0) ? 9'(modulus - rem_next) : rem_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == CW'(1)) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd     <= raw_abs[DW-1:0];
      div_neg <= raw_sel[RW-1];
      div_y   <= cmd.div_y;
      modulus <= cmd.div_y ? map_height : map_width;
      rem     <= 9'd0;
      div_cnt <= CW'(DW);
    end else if (div_busy) begin
      dvd     <= dvd << 1;
      rem     <= rem_next;
      div_cnt <= div_cnt - CW'(1);
      if (div_cnt == CW'(1)) begin
        if (div_y) y0 <= wrapped;
        else       x0 <= wrapped;
      end
    end
  end

  assign walk_addr = MAW'(base + AW'(wx));

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      base <= AW'(y0) * AW'(map_width);
      wx   <= x0;
      wy   <= y0;
      sx   <= '0;
      tcnt <= '0;
    end else if (cmd.splat_step) begin
      tcnt <= tcnt + TW'(1);
      if (32'(sx) == STAMP_SIDE - 1) begin
        sx <= '0;
        wx <= x0;
        if (wy == map_height - 9'd1) begin
          wy   <= 9'd0;
          base <= '0;
        end else begin
          wy   <= wy + 9'd1;
          base <= base + AW'(map_width);
        end
      end else begin
        sx <= sx + SXW'(1);
        wx <= (wx == map_width - 9'd1) ? 9'd0 : wx + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // forward the previous sum when the same pixel is hit twice in a row
  assign sum = ((p2_valid && p2_addr == p1_addr) ? p2_sum : map_q) + stamp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.splat_step;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr <= walk_addr;
    p2_addr <= p1_addr;
    p2_sum  <= sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.splat_step) begin
      map_q <= map_mem[walk_addr];
    end else if (cmd.read_issue) begin
      map_q <= map_mem[MAW'(idx_q)];
    end
    if (cmd.clear_step) begin
      map_mem[MAW'(clr_cnt)] <= 8'd0;
    end else if (p1_valid) begin
      map_mem[p1_addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.splat_step) begin
      stamp_q <= stamp_mem[tcnt];
    end
    if (cmd.load_write) begin
      stamp_mem[idx_q[TW-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      m_tdata <= cmd.resp_read ? map_q : 8'd0;
      m_tuser <= cmd.resp_err;
    end
  end

endmodule

// File: rtl/sssa_ctrl.sv
module sssa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  sssa_pkg::stat_t stat,
  output sssa_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CLEAR, S_SCALE, S_DIVX_GO, S_DIVX_WAIT, S_DIVY_GO,
    S_DIVY_WAIT, S_WALK, S_RUN, S_DRAIN, S_RWAIT, S_DONE
  } state_t;

  state_t state;
  logic   err_q;
  logic   rd_q;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd            = '0;
    cmd.resp_err   = err_q;
    cmd.resp_read  = rd_q;
    cmd.capture    = (state == S_IDLE) && s_tvalid;
    cmd.scale      = (state == S_SCALE);
    cmd.div_start  = (state == S_DIVX_GO) || (state == S_DIVY_GO);
    cmd.div_y      = (state == S_DIVY_GO);
    cmd.walk_init  = (state == S_WALK);
    cmd.clear_step = (state == S_CLEAR);
    cmd.splat_step = (state == S_RUN);
    cmd.load_write = (state == S_PREP) && (stat.op == sssa_pkg::OP_LOAD) && stat.load_ok;
    cmd.read_issue = (state == S_PREP) && (stat.op == sssa_pkg::OP_READ) && stat.read_ok;
    cmd.resp_load  = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_q    <= 1'b0;
      rd_q     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.resp_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            err_q <= 1'b0;
            rd_q  <= 1'b0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          unique case (stat.op)
            sssa_pkg::OP_CLEAR: begin
              err_q <= !stat.dims_ok;
              state <= stat.dims_ok ? S_CLEAR : S_DONE;
            end
            sssa_pkg::OP_LOAD: begin
              err_q <= !stat.load_ok;
              state <= S_DONE;
            end
            sssa_pkg::OP_SPLAT: begin
              err_q <= !stat.dims_ok;
              state <= stat.dims_ok ? S_SCALE : S_DONE;
            end
            default: begin
              err_q <= !stat.read_ok;
              rd_q  <= stat.read_ok;
              state <= stat.read_ok ? S_RWAIT : S_DONE;
            end
          endcase
        end
        S_CLEAR:     if (stat.clear_last) state <= S_DONE;
        S_SCALE:     state <= S_DIVX_GO;
        S_DIVX_GO:   state <= S_DIVX_WAIT;
        S_DIVX_WAIT: if (!stat.div_busy) state <= S_DIVY_GO;
        S_DIVY_GO:   state <= S_DIVY_WAIT;
        S_DIVY_WAIT: if (!stat.div_busy) state <= S_WALK;
        S_WALK:      state <= S_RUN;
        S_RUN:       if (stat.texel_last) state <= S_DRAIN;
        S_DRAIN:     state <= S_DONE;
        S_RWAIT:     state <= S_DONE;
        S_DONE:      if (out_free) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/shadow_stamp_splat_accumulator.sv
// A clear zeroes map_width*map_height cells; a splat scales the position, takes the
// two wrap remainders, then walks the STAMP_SIDE*STAMP_SIDE texels.
// Throughput: one item at a time; a splat is bound by the map memory, one
// texel read-add-write per cycle.
// Reset (synchronous, rst high) restores the config registers and idles the controller;
// map and stamp contents are kept and are defined only once cleared or loaded.
module shadow_stamp_splat_accumulator #(
  parameter int STAMP_SIDE    = 16,
  parameter int MAP_SIDE_MAX  = 256,
  parameter int POS_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // index[15:0], value[23:16], pos_x[39:24], pos_y[55:40]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // read_value[7:0]
  output logic        m_tuser    // status[0]
);

  sssa_pkg::cmd_t  cmd;
  sssa_pkg::stat_t stat;

  sssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sssa_datapath #(
    .STAMP_SIDE    (STAMP_SIDE),
    .MAP_SIDE_MAX  (MAP_SIDE_MAX),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: rtl/sssa_checker.sv
module sssa_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken before the first finished");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared the cycle after accept");

  a_err_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0)
    else $error("error beat carries data");

endmodule

bind shadow_stamp_splat_accumulator sssa_checker u_sssa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
